FILE: hw/rtl/checksummed_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Checksummed frame receiver assertion macros
// Shared concurrent assertion wrappers clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

// Checked only while the block is out of reset.
`define CFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver package
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int unsigned PAYLOAD_LEN  = 8;
    localparam int unsigned CHECKSUM_LEN = 4;

    localparam logic [7:0] FIRST_HEADER_RST  = 8'h55;
    localparam logic [7:0] SECOND_HEADER_RST = 8'hAA;
    localparam logic [7:0] TAIL_VALUE_RST    = 8'h0D;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_word;

    typedef enum logic [1:0] {
        CFG_FIRST_HEADER  = 2'd0,
        CFG_SECOND_HEADER = 2'd1,
        CFG_TAIL_VALUE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_byte first_header;
        t_byte second_header;
        t_byte tail_value;
    } t_cfg;

    typedef enum logic [4:0] {
        PH_HEAD1 = 5'b00001,
        PH_HEAD2 = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_CSUM  = 5'b01000,
        PH_TAIL  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic  hit;
        t_word first_word;
        t_word second_word;
    } t_result;

endpackage

FILE: hw/rtl/cfr_byte_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received serial byte per transaction.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
    import cfr_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/cfr_result_if.sv
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying the two payload words of one good frame.
// ----------------------------------------------------------------------------
interface cfr_result_if;
    import cfr_pkg::*;

    logic  valid;
    logic  ready;
    t_word first_word;
    t_word second_word;

    modport source (output valid, output first_word, output second_word, input ready);
    modport sink   (input valid, input first_word, input second_word, output ready);
endinterface

FILE: hw/rtl/checksummed_frame_receiver.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver
// Hunts for header/payload/checksum/tail frames in a byte stream and returns
// the payload of each good frame as two little-endian 32-bit words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                      Transaction
//  i_rx      in         rx_byte (8 bit)              valid && ready
//  o_res     out        first_word, second_word      valid && ready
//  i_cfg_*   in         i_cfg_idx, i_cfg_data        i_cfg_we
//
//  One byte is accepted per cycle unless a result stalls; a byte is registered
//  and then parsed; a result is visible the cycle after its tail byte is parsed.
//  Reset is synchronous and active low; it clears the frame state and loads the
//  default header and tail values. The payload store is not reset.
//  A stalled result holds the parser; the input register still takes one byte.
// ----------------------------------------------------------------------------
`include "checksummed_frame_receiver_macros.svh"

module checksummed_frame_receiver
    import cfr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    cfr_byte_if.sink            i_rx,
    cfr_result_if.source        o_res,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_word   r_first_word, r_second_word;
    logic    adv;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header  <= FIRST_HEADER_RST;
            r_cfg.second_header <= SECOND_HEADER_RST;
            r_cfg.tail_value    <= TAIL_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_HEADER:  r_cfg.first_header  <= i_cfg_data;
                CFG_SECOND_HEADER: r_cfg.second_header <= i_cfg_data;
                CFG_TAIL_VALUE:    r_cfg.tail_value    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The parser moves when the result register is free or being emptied.
    assign adv        = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    cfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv && r_in_valid),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= result.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && result.hit) begin
            r_first_word  <= result.first_word;
            r_second_word <= result.second_word;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.first_word  = r_first_word;
    assign o_res.second_word = r_second_word;

    `CFR_ASSERT(a_result_from_byte, $rose(r_out_valid) |-> $past(r_in_valid), "result appeared without a parsed byte")
    `CFR_ASSERT(a_in_held, (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_byte)), "pending byte lost while the result stalled")
    `CFR_ASSERT_ALWAYS(a_ready_when_empty, (i_rst_n && !r_out_valid) |-> i_rx.ready, "input stalled with an empty result register")

endmodule

FILE: hw/rtl/cfr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Per-byte frame state, payload store, running sum and checksum gathering.
// ----------------------------------------------------------------------------
`include "checksummed_frame_receiver_macros.svh"

module cfr_parser
    import cfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_byte   i_byte,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int unsigned CNT_W  = $clog2(PAYLOAD_LEN + 1);
    localparam int unsigned IDX_W  = $clog2(PAYLOAD_LEN);
    localparam int unsigned CCNT_W = $clog2(CHECKSUM_LEN + 1);
    localparam int unsigned CIDX_W = $clog2(CHECKSUM_LEN);
    localparam int unsigned SUM_W  = 11;

    t_phase            r_phase, n_phase;
    t_byte             r_store [PAYLOAD_LEN];
    logic [CNT_W-1:0]  r_payload_count, n_payload_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    t_word             r_sent, n_sent;
    logic [CCNT_W-1:0] r_csum_count, n_csum_count;
    logic              store_we;
    logic              sum_match;
    logic              hit;

    // The payload sum is at most 2040, so the upper checksum bits must be zero.
    assign sum_match = (r_sent[31:SUM_W] == '0) && (r_sent[SUM_W-1:0] == r_sum);

    always_comb begin
        n_phase         = r_phase;
        n_payload_count = r_payload_count;
        n_sum           = r_sum;
        n_sent          = r_sent;
        n_csum_count    = r_csum_count;
        store_we        = 1'b0;
        hit             = 1'b0;
        case (r_phase)
            PH_HEAD2: begin
                if (i_byte == i_cfg.second_header) begin
                    n_phase         = PH_DATA;
                    n_payload_count = '0;
                    n_sum           = '0;
                end else if (i_byte == i_cfg.first_header) begin
                    n_phase = PH_HEAD2;
                end else begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_DATA: begin
                store_we        = 1'b1;
                n_sum           = r_sum + SUM_W'(i_byte);
                n_payload_count = r_payload_count + CNT_W'(1);
                if (n_payload_count >= CNT_W'(PAYLOAD_LEN)) begin
                    n_phase      = PH_CSUM;
                    n_csum_count = '0;
                    n_sent       = '0;
                end
            end
            PH_CSUM: begin
                n_sent       = r_sent | (t_word'(i_byte) << {r_csum_count[CIDX_W-1:0], 3'b000});
                n_csum_count = r_csum_count + CCNT_W'(1);
                if (n_csum_count >= CCNT_W'(CHECKSUM_LEN)) begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                hit     = i_step && (i_byte == i_cfg.tail_value) && sum_match;
                n_phase = PH_HEAD1;
            end
            default: begin
                n_phase = (i_byte == i_cfg.first_header) ? PH_HEAD2 : PH_HEAD1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEAD1;
            r_payload_count <= '0;
            r_sum           <= '0;
            r_sent          <= '0;
            r_csum_count    <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_payload_count <= n_payload_count;
            r_sum           <= n_sum;
            r_sent          <= n_sent;
            r_csum_count    <= n_csum_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_payload_count[IDX_W-1:0]] <= i_byte;
        end
    end

    assign o_result.hit         = hit;
    assign o_result.first_word  = {r_store[3], r_store[2], r_store[1], r_store[0]};
    assign o_result.second_word = {r_store[7], r_store[6], r_store[5], r_store[4]};

    `CFR_ASSERT(a_tail_restarts, (i_step && r_phase == PH_TAIL) |=> (r_phase == PH_HEAD1), "frame hunt did not restart after the tail byte")
    `CFR_ASSERT(a_csum_after_payload, (r_phase == PH_CSUM || r_phase == PH_TAIL) |-> (r_payload_count == CNT_W'(PAYLOAD_LEN)), "checksum phase entered without a full payload")
    `CFR_ASSERT(a_hit_in_tail, o_result.hit |-> (r_phase == PH_TAIL && r_csum_count == CCNT_W'(CHECKSUM_LEN)), "frame result outside the tail phase")

endmodule
